// ===== rtl/glsc_pkg.sv =====
// Shared types and constants for the glide slope light color unit.
// No dependencies; every rtl file refers to it by scoped names.
package glsc_pkg;

	// Datapath widths
	localparam int SQ_W        = 62;
	localparam int LEN_W       = 31;
	localparam int AB_W        = 52;
	localparam int QUO_W       = 30;
	localparam int SQRT_STEPS  = 31;
	localparam int DIV_STEPS   = 30;
	localparam int CH_STEPS    = 8;
	localparam int K_MAX       = 10;

	// Constants of the fixed point math
	localparam logic [SQ_W-1:0] NEAR_SQ      = 62'd4295;       // 1 mm squared, Q.32
	localparam logic [20:0]     ANGLE_SAT    = 21'd1800000;    // microdegrees
	localparam logic [25:0]     UDEG_PER_RAD = 26'd57295780;
	localparam logic [15:0]     RECIP6       = 16'd43691;      // ceil(2^18 / 6)
	localparam logic [9:0]      TU_SCALE     = 10'd1000;

	// Config register indexes
	typedef enum logic [1:0] {
		REG_RED   = 2'd0,
		REG_WHITE = 2'd1,
		REG_TRANS = 2'd2
	} reg_idx_t;

	localparam logic [31:0] RED_RESET   = 32'hFF0000FF;
	localparam logic [31:0] WHITE_RESET = 32'hFFFFFFFF;
	localparam logic [9:0]  TRANS_RESET = 10'd50;

	typedef logic signed [31:0] pos_t;
	typedef logic signed [15:0] coef_t;
	typedef logic signed [32:0] d_t;
	typedef logic signed [48:0] dp_t;
	typedef logic signed [50:0] dot_t;
	typedef logic signed [36:0] dh_t;
	typedef logic signed [52:0] hdh_t;
	typedef logic signed [39:0] p_t;
	typedef logic        [39:0] pmag_t;
	typedef logic        [3:0]  k_t;
	typedef logic signed [31:0] q_t;
	typedef logic signed [18:0] up_t;
	typedef logic signed [50:0] qu_t;
	typedef logic        [60:0] qq_t;
	typedef logic signed [52:0] b_t;
	typedef logic [AB_W-1:0]    ab_t;
	typedef logic [SQ_W-1:0]    sq_t;
	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [QUO_W-1:0]   quo_t;
	typedef logic signed [21:0] ang_t;
	typedef logic        [19:0] tu_t;
	typedef logic        [20:0] den_t;
	typedef logic        [29:0] num_t;
	typedef logic        [7:0]  chan_t;

	typedef struct packed {
		pos_t  eye_x;
		pos_t  eye_y;
		pos_t  eye_z;
		pos_t  light_x;
		pos_t  light_y;
		pos_t  light_z;
		coef_t normal_x;
		coef_t normal_y;
		coef_t normal_z;
		coef_t horiz_x;
		coef_t horiz_y;
		coef_t horiz_z;
	} in_t;

	// Side data carried along the sqrt stages
	typedef struct packed {
		logic hide;
		logic neg;
		ab_t  ab;
	} side_t;

	// Side data leaving the sine divider
	typedef struct packed {
		logic hide;
		logic neg;
		logic sat;
	} sine_side_t;

	typedef struct packed {
		logic [31:0] red_color;
		logic [31:0] white_color;
		logic [9:0]  trans;
	} cfg_t;

	typedef struct packed {
		logic  visible;
		chan_t red;
		chan_t green;
		chan_t blue;
		chan_t alpha;
	} res_t;

endpackage

// ===== rtl/glide_slope_light_color_unit.sv =====
// Glide slope light color unit: one word per cycle sustained while m_tready stays high.
// Depth is set by the 31-stage square root and the sine divider (a set-up stage and
// 30 quotient stages), one result bit per quotient stage.
// Reset clears every valid bit and loads the color and transition registers with
// their defaults; there is no clearing pass, s_tready is high right after reset.
module glide_slope_light_color_unit (
	input  logic         clk,
	input  logic         arst_n,
	// config write port
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// input words
	input  logic         s_tvalid,
	output logic         s_tready,
	// eye_x, eye_y, eye_z, light_x, light_y, light_z (32 each),
	// normal_x, normal_y, normal_z, horiz_x, horiz_y, horiz_z (16 each)
	input  logic [287:0] s_tdata,
	// result words
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_red, out_green, out_blue, out_alpha (8 each)
	output logic [31:0]  m_tdata,
	// visible
	output logic         m_tuser
);

	glsc_pkg::cfg_t cfg_q;

	logic                 en;
	glsc_pkg::in_t        item;
	logic                 vec_v, sqrt_v, div_v, pipe_v;
	glsc_pkg::side_t      vec_side, sqrt_side;
	glsc_pkg::sq_t        vec_sq;
	glsc_pkg::len_t       sqrt_len;
	glsc_pkg::sine_side_t div_side;
	glsc_pkg::quo_t       div_quo;
	glsc_pkg::res_t       pipe_res;

	logic                 out_v_q, skid_v_q;
	glsc_pkg::res_t       out_q, skid_q;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_color   <= glsc_pkg::RED_RESET;
			cfg_q.white_color <= glsc_pkg::WHITE_RESET;
			cfg_q.trans       <= glsc_pkg::TRANS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				glsc_pkg::REG_RED:   cfg_q.red_color   <= cfg_data;
				glsc_pkg::REG_WHITE: cfg_q.white_color <= cfg_data;
				glsc_pkg::REG_TRANS: cfg_q.trans       <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Unpack the input word
	always_comb begin
		item.eye_x    = s_tdata[31:0];
		item.eye_y    = s_tdata[63:32];
		item.eye_z    = s_tdata[95:64];
		item.light_x  = s_tdata[127:96];
		item.light_y  = s_tdata[159:128];
		item.light_z  = s_tdata[191:160];
		item.normal_x = s_tdata[207:192];
		item.normal_y = s_tdata[223:208];
		item.normal_z = s_tdata[239:224];
		item.horiz_x  = s_tdata[255:240];
		item.horiz_y  = s_tdata[271:256];
		item.horiz_z  = s_tdata[287:272];
	end

	// The whole pipeline moves unless the skid register is holding a word
	assign en       = ~skid_v_q;
	assign s_tready = en;

	glsc_vec u_vec (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_item   (item),
		.out_valid (vec_v),
		.out_side  (vec_side),
		.out_sq    (vec_sq)
	);

	glsc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vec_v),
		.in_side   (vec_side),
		.in_sq     (vec_sq),
		.out_valid (sqrt_v),
		.out_side  (sqrt_side),
		.out_len   (sqrt_len)
	);

	glsc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sqrt_v),
		.in_side   (sqrt_side),
		.in_len    (sqrt_len),
		.out_valid (div_v),
		.out_side  (div_side),
		.out_quo   (div_quo)
	);

	glsc_color u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.in_valid  (div_v),
		.in_side   (div_side),
		.in_quo    (div_quo),
		.out_valid (pipe_v),
		.out_res   (pipe_res)
	);

	// Output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_tready)
				skid_v_q <= 1'b0;
		end else if (out_v_q && !m_tready) begin
			if (pipe_v)
				skid_v_q <= 1'b1;
		end else begin
			out_v_q <= pipe_v;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_tready)
				out_q <= skid_q;
		end else if (out_v_q && !m_tready) begin
			skid_q <= pipe_res;
		end else begin
			out_q <= pipe_res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.visible;
	assign m_tdata  = {out_q.alpha, out_q.blue, out_q.green, out_q.red};

endmodule

// ===== rtl/glsc_vec.sv =====
// Vector front end: eye vector, facing test, projection, scaling, dot products.
// Nine pipeline stages; uses glsc_pkg.
module glsc_vec (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  glsc_pkg::in_t      in_item,
	output logic               out_valid,
	output glsc_pkg::side_t    out_side,
	output glsc_pkg::sq_t      out_sq
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	glsc_pkg::pos_t  eye [3];
	glsc_pkg::pos_t  lit [3];
	glsc_pkg::coef_t nin [3];
	glsc_pkg::coef_t hin [3];

	glsc_pkg::d_t    d_s1 [3], d_s2 [3], d_s3 [3], d_s4 [3];
	glsc_pkg::coef_t n_s1 [3], h_s1 [3], h_s2 [3], h_s3 [3];
	glsc_pkg::dp_t   dnp_s2 [3], dhp_s2 [3];
	glsc_pkg::up_t   up_s2 [3], up_s3 [3], up_s4 [3], up_s5 [3], up_s6 [3], up_s7 [3];
	logic            behind_s3, behind_s4, behind_s5, behind_s6, behind_s7, behind_s8;
	glsc_pkg::dh_t   dh_s3;
	glsc_pkg::hdh_t  hdh_s4 [3];
	glsc_pkg::p_t    p_s5 [3], p_s6 [3];
	glsc_pkg::k_t    k_s6;
	glsc_pkg::q_t    q_s7 [3];
	logic            k0_s7, k0_s8;
	glsc_pkg::qq_t   qq_s8 [3];
	glsc_pkg::qu_t   qu_s8 [3];
	glsc_pkg::side_t side_s9;
	glsc_pkg::sq_t   sq_s9;

	// Combinational terms of each stage
	logic signed [31:0] crs_a [3], crs_b [3];
	logic signed [32:0] crs_d [3];
	glsc_pkg::up_t      up_c [3];
	glsc_pkg::dot_t     dn_sum, dh_sum;
	glsc_pkg::pmag_t    pmag [3];
	glsc_pkg::pmag_t    por;
	glsc_pkg::k_t       k_c;
	logic signed [63:0] qsq [3];
	glsc_pkg::sq_t      sq_c;
	glsc_pkg::b_t       b_c;

	always_comb begin
		eye[0] = in_item.eye_x;    eye[1] = in_item.eye_y;    eye[2] = in_item.eye_z;
		lit[0] = in_item.light_x;  lit[1] = in_item.light_y;  lit[2] = in_item.light_z;
		nin[0] = in_item.normal_x; nin[1] = in_item.normal_y; nin[2] = in_item.normal_z;
		hin[0] = in_item.horiz_x;  hin[1] = in_item.horiz_y;  hin[2] = in_item.horiz_z;
	end

	// up = normal x horizontal, floor shifted back to Q1.14
	always_comb begin
		crs_a[0] = n_s1[1] * h_s1[2];  crs_b[0] = n_s1[2] * h_s1[1];
		crs_a[1] = n_s1[2] * h_s1[0];  crs_b[1] = n_s1[0] * h_s1[2];
		crs_a[2] = n_s1[0] * h_s1[1];  crs_b[2] = n_s1[1] * h_s1[0];
		for (int i = 0; i < 3; i++) begin
			crs_d[i] = 33'(crs_a[i]) - 33'(crs_b[i]);
			up_c[i]  = crs_d[i][32:14];
		end
	end

	// Dot products with normal and horizontal
	always_comb begin
		dn_sum = glsc_pkg::dot_t'(dnp_s2[0]) + glsc_pkg::dot_t'(dnp_s2[1])
			+ glsc_pkg::dot_t'(dnp_s2[2]);
		dh_sum = glsc_pkg::dot_t'(dhp_s2[0]) + glsc_pkg::dot_t'(dhp_s2[1])
			+ glsc_pkg::dot_t'(dhp_s2[2]);
	end

	// Scale shift: smallest k that brings every |p| below 2^30
	always_comb begin
		for (int i = 0; i < 3; i++)
			pmag[i] = p_s5[i][39] ? glsc_pkg::pmag_t'(-p_s5[i]) : glsc_pkg::pmag_t'(p_s5[i]);
		por = pmag[0] | pmag[1] | pmag[2];
		k_c = '0;
		for (int kk = glsc_pkg::K_MAX; kk >= 0; kk--) begin
			if ((por >> kk) < 40'h0040000000)
				k_c = glsc_pkg::k_t'(kk);
		end
	end

	// Squared length and elevation dot product
	always_comb begin
		for (int i = 0; i < 3; i++)
			qsq[i] = q_s7[i] * q_s7[i];
		sq_c = glsc_pkg::sq_t'(qq_s8[0]) + glsc_pkg::sq_t'(qq_s8[1])
			+ glsc_pkg::sq_t'(qq_s8[2]);
		b_c  = glsc_pkg::b_t'(qu_s8[0]) + glsc_pkg::b_t'(qu_s8[1])
			+ glsc_pkg::b_t'(qu_s8[2]);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				// s1: eye vector
				d_s1[i]   <= glsc_pkg::d_t'(eye[i]) - glsc_pkg::d_t'(lit[i]);
				n_s1[i]   <= nin[i];
				h_s1[i]   <= hin[i];
				// s2: products
				dnp_s2[i] <= d_s1[i] * n_s1[i];
				dhp_s2[i] <= d_s1[i] * h_s1[i];
				up_s2[i]  <= up_c[i];
				d_s2[i]   <= d_s1[i];
				h_s2[i]   <= h_s1[i];
				// s3
				d_s3[i]   <= d_s2[i];
				h_s3[i]   <= h_s2[i];
				up_s3[i]  <= up_s2[i];
				// s4: horizontal part
				hdh_s4[i] <= h_s3[i] * dh_s3;
				d_s4[i]   <= d_s3[i];
				up_s4[i]  <= up_s3[i];
				// s5: projection
				p_s5[i]   <= glsc_pkg::p_t'(d_s4[i]) - glsc_pkg::p_t'(hdh_s4[i] >>> 14);
				up_s5[i]  <= up_s4[i];
				// s6
				p_s6[i]   <= p_s5[i];
				up_s6[i]  <= up_s5[i];
				// s7: scaled vector
				q_s7[i]   <= glsc_pkg::q_t'(p_s6[i] >>> k_s6);
				up_s7[i]  <= up_s6[i];
				// s8
				qq_s8[i]  <= qsq[i][60:0];
				qu_s8[i]  <= q_s7[i] * up_s7[i];
			end
			behind_s3 <= (dn_sum <= 0);
			dh_s3     <= glsc_pkg::dh_t'(dh_sum >>> 14);
			behind_s4 <= behind_s3;
			behind_s5 <= behind_s4;
			behind_s6 <= behind_s5;
			k_s6      <= k_c;
			behind_s7 <= behind_s6;
			k0_s7     <= (k_s6 == '0);
			behind_s8 <= behind_s7;
			k0_s8     <= k0_s7;
			// s9: hide test, sign and magnitude of the elevation dot
			side_s9.hide <= behind_s8 | (k0_s8 & (sq_c < glsc_pkg::NEAR_SQ));
			side_s9.neg  <= b_c[52];
			side_s9.ab   <= b_c[52] ? glsc_pkg::ab_t'(-b_c) : glsc_pkg::ab_t'(b_c);
			sq_s9        <= sq_c;
		end
	end

	assign out_valid = v_s9;
	assign out_side  = side_s9;
	assign out_sq    = sq_s9;

endmodule

// ===== rtl/glsc_sqrt.sv =====
// Pipelined integer square root of the squared projection length, one root bit per stage.
// Uses glsc_pkg.
module glsc_sqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  glsc_pkg::side_t in_side,
	input  glsc_pkg::sq_t   in_sq,
	output logic            out_valid,
	output glsc_pkg::side_t out_side,
	output glsc_pkg::len_t  out_len
);

	localparam int Steps = glsc_pkg::SQRT_STEPS;

	logic            v_s    [Steps];
	glsc_pkg::side_t side_s [Steps];
	logic [32:0]     rem_s  [Steps];
	glsc_pkg::len_t  root_s [Steps];
	glsc_pkg::sq_t   rad_s  [Steps];

	for (genvar g = 0; g < Steps; g++) begin : g_step
		logic            pv;
		glsc_pkg::side_t pside;
		logic [32:0]     prem;
		glsc_pkg::len_t  proot;
		glsc_pkg::sq_t   prad;
		logic [34:0]     r2, trial, diff;
		logic            ge;

		if (g == 0) begin : g_first
			assign pv    = in_valid;
			assign pside = in_side;
			assign prem  = '0;
			assign proot = '0;
			assign prad  = in_sq;
		end else begin : g_next
			assign pv    = v_s[g-1];
			assign pside = side_s[g-1];
			assign prem  = rem_s[g-1];
			assign proot = root_s[g-1];
			assign prad  = rad_s[g-1];
		end

		// Bring down two radicand bits and try root*4+1
		assign r2    = {prem, prad[61:60]};
		assign trial = {2'b00, proot, 2'b01};
		assign diff  = r2 - trial;
		assign ge    = (r2 >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g] <= pside;
				rem_s[g]  <= ge ? diff[32:0] : r2[32:0];
				root_s[g] <= {proot[29:0], ge};
				rad_s[g]  <= {prad[59:0], 2'b00};
			end
		end
	end

	assign out_valid = v_s[Steps-1];
	assign out_side  = side_s[Steps-1];
	assign out_len   = root_s[Steps-1];

endmodule

// ===== rtl/glsc_div.sv =====
// Sine divider: saturation test, then restoring division |b|*2^16 / len, one bit per stage.
// Uses glsc_pkg.
module glsc_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  glsc_pkg::side_t      in_side,
	input  glsc_pkg::len_t       in_len,
	output logic                 out_valid,
	output glsc_pkg::sine_side_t out_side,
	output glsc_pkg::quo_t       out_quo
);

	localparam int Steps = glsc_pkg::DIV_STEPS;

	// s0: saturation and remainder set-up
	logic                 v_s0;
	glsc_pkg::sine_side_t side_s0;
	logic [31:0]          rem_s0;
	logic [29:0]          lo_s0;
	glsc_pkg::len_t       den_s0;

	logic                 v_s    [Steps];
	glsc_pkg::sine_side_t side_s [Steps];
	logic [31:0]          rem_s  [Steps];
	logic [29:0]          lo_s   [Steps];
	glsc_pkg::len_t       den_s  [Steps];
	glsc_pkg::quo_t       quo_s  [Steps];

	logic [45:0] len_sh;

	assign len_sh = {in_len, 14'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= in_valid;
		end
	end

	// Numerator bits above 30 seed the remainder; the low 30 shift in later
	always_ff @(posedge clk) begin
		if (en) begin
			side_s0.hide <= in_side.hide;
			side_s0.neg  <= in_side.neg;
			side_s0.sat  <= (in_side.ab >= glsc_pkg::ab_t'(len_sh));
			rem_s0       <= in_side.ab[45:14];
			lo_s0        <= {in_side.ab[13:0], 16'd0};
			den_s0       <= in_len;
		end
	end

	for (genvar g = 0; g < Steps; g++) begin : g_step
		logic                 pv;
		glsc_pkg::sine_side_t pside;
		logic [31:0]          prem;
		logic [29:0]          plo;
		glsc_pkg::len_t       pden;
		glsc_pkg::quo_t       pquo;
		logic [32:0]          r2, diff;
		logic                 ge;

		if (g == 0) begin : g_first
			assign pv    = v_s0;
			assign pside = side_s0;
			assign prem  = rem_s0;
			assign plo   = lo_s0;
			assign pden  = den_s0;
			assign pquo  = '0;
		end else begin : g_next
			assign pv    = v_s[g-1];
			assign pside = side_s[g-1];
			assign prem  = rem_s[g-1];
			assign plo   = lo_s[g-1];
			assign pden  = den_s[g-1];
			assign pquo  = quo_s[g-1];
		end

		assign r2   = {prem, plo[29]};
		assign diff = r2 - 33'(pden);
		assign ge   = (r2 >= 33'(pden));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g] <= pside;
				rem_s[g]  <= ge ? diff[31:0] : r2[31:0];
				lo_s[g]   <= {plo[28:0], 1'b0};
				den_s[g]  <= pden;
				quo_s[g]  <= {pquo[28:0], ge};
			end
		end
	end

	assign out_valid = v_s[Steps-1];
	assign out_side  = side_s[Steps-1];
	assign out_quo   = quo_s[Steps-1];

endmodule

// ===== rtl/glsc_color.sv =====
// Angle series, band test and per-channel color blend with an 8-step divider.
// Uses glsc_pkg; reads the config registers held in the top level.
module glsc_color (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  glsc_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	input  glsc_pkg::sine_side_t in_side,
	input  glsc_pkg::quo_t       in_quo,
	output logic                 out_valid,
	output glsc_pkg::res_t       out_res
);

	localparam int Steps = glsc_pkg::CH_STEPS;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic hide_s1, hide_s2, hide_s3, hide_s4, hide_s5, hide_s6, hide_s7;
	logic neg_s1, neg_s2, neg_s3, neg_s4;
	logic sat_s1, sat_s2, sat_s3, sat_s4;
	logic below_s6, below_s7, above_s6, above_s7;

	logic [24:0]         x_s1, x_s2;
	logic [49:0]         xx_s1;
	logic [44:0]         xxx_s2;
	logic [25:0]         r_s3;
	logic [51:0]         rp_s4;
	glsc_pkg::ang_t      angle_s5;
	glsc_pkg::den_t      ta_s6, tb_s6;
	glsc_pkg::num_t      num_s7 [4];

	logic                v_s     [Steps];
	logic                hide_s  [Steps];
	logic                below_s [Steps];
	logic                above_s [Steps];
	logic [21:0]         rem_s   [Steps][4];
	logic [7:0]          lo_s    [Steps][4];
	glsc_pkg::chan_t     quo_s   [Steps][4];

	logic [14:0]         c_c;
	logic [30:0]         c6_c;
	logic [20:0]         mag_c;
	glsc_pkg::tu_t       tu;
	glsc_pkg::den_t      den;
	logic signed [22:0]  a23, tu23, ta_c, tb_c;
	glsc_pkg::chan_t     rc [4], wc [4];

	assign tu  = cfg.trans * glsc_pkg::TU_SCALE;
	assign den = {tu, 1'b0};

	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			rc[ch] = cfg.red_color[31 - 8*ch -: 8];
			wc[ch] = cfg.white_color[31 - 8*ch -: 8];
		end
	end

	// Cubic term over six, by reciprocal multiply
	always_comb begin
		c_c  = xxx_s2[44:30];
		c6_c = c_c * glsc_pkg::RECIP6;
	end

	// Angle magnitude, and band edges against +-Tu
	always_comb begin
		mag_c = sat_s4 ? glsc_pkg::ANGLE_SAT : rp_s4[50:30];
		a23   = 23'(angle_s5);
		tu23  = $signed({3'b000, tu});
		ta_c  = tu23 - a23;
		tb_c  = tu23 + a23;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: x squared
			sat_s1  <= in_side.sat | (|in_quo[29:25]);
			x_s1    <= in_quo[24:0];
			xx_s1   <= in_quo[24:0] * in_quo[24:0];
			hide_s1 <= in_side.hide;
			neg_s1  <= in_side.neg;
			// s2: x cubed
			xxx_s2  <= xx_s1[49:30] * x_s1;
			x_s2    <= x_s1;
			sat_s2  <= sat_s1;
			hide_s2 <= hide_s1;
			neg_s2  <= neg_s1;
			// s3: series x + x^3/6
			r_s3    <= 26'(x_s2) + 26'(c6_c[30:18]);
			sat_s3  <= sat_s2;
			hide_s3 <= hide_s2;
			neg_s3  <= neg_s2;
			// s4: to microdegrees
			rp_s4   <= r_s3 * glsc_pkg::UDEG_PER_RAD;
			sat_s4  <= sat_s3;
			hide_s4 <= hide_s3;
			neg_s4  <= neg_s3;
			// s5: signed angle
			angle_s5 <= neg_s4 ? -glsc_pkg::ang_t'(mag_c) : glsc_pkg::ang_t'(mag_c);
			hide_s5  <= hide_s4;
			// s6: band test
			below_s6 <= (tb_c < 0);
			above_s6 <= (a23 >= tu23);
			ta_s6    <= ta_c[20:0];
			tb_s6    <= tb_c[20:0];
			hide_s6  <= hide_s5;
			// s7: blend numerators
			for (int ch = 0; ch < 4; ch++)
				num_s7[ch] <= rc[ch] * ta_s6 + wc[ch] * tb_s6;
			below_s7 <= below_s6;
			above_s7 <= above_s6;
			hide_s7  <= hide_s6;
		end
	end

	// Divide by 2*Tu, one quotient bit per stage
	for (genvar g = 0; g < Steps; g++) begin : g_step
		logic            pv, phide, pbelow, pabove;
		logic [21:0]     prem [4];
		logic [7:0]      plo  [4];
		glsc_pkg::chan_t pquo [4];
		logic [22:0]     r2 [4], diff [4];
		logic [3:0]      ge;

		if (g == 0) begin : g_first
			assign pv     = v_s7;
			assign phide  = hide_s7;
			assign pbelow = below_s7;
			assign pabove = above_s7;
			always_comb begin
				for (int ch = 0; ch < 4; ch++) begin
					prem[ch] = num_s7[ch][29:8];
					plo[ch]  = num_s7[ch][7:0];
					pquo[ch] = '0;
				end
			end
		end else begin : g_next
			assign pv     = v_s[g-1];
			assign phide  = hide_s[g-1];
			assign pbelow = below_s[g-1];
			assign pabove = above_s[g-1];
			always_comb begin
				for (int ch = 0; ch < 4; ch++) begin
					prem[ch] = rem_s[g-1][ch];
					plo[ch]  = lo_s[g-1][ch];
					pquo[ch] = quo_s[g-1][ch];
				end
			end
		end

		always_comb begin
			for (int ch = 0; ch < 4; ch++) begin
				r2[ch]   = {prem[ch], plo[ch][7]};
				diff[ch] = r2[ch] - 23'(den);
				ge[ch]   = (r2[ch] >= 23'(den));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hide_s[g]  <= phide;
				below_s[g] <= pbelow;
				above_s[g] <= pabove;
				for (int ch = 0; ch < 4; ch++) begin
					rem_s[g][ch] <= ge[ch] ? diff[ch][21:0] : r2[ch][21:0];
					lo_s[g][ch]  <= {plo[ch][6:0], 1'b0};
					quo_s[g][ch] <= {pquo[ch][6:0], ge[ch]};
				end
			end
		end
	end

	// Final selection of red, white or blend; hidden lights give zeros
	glsc_pkg::chan_t pick [4];

	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			if (hide_s[Steps-1])
				pick[ch] = '0;
			else if (below_s[Steps-1])
				pick[ch] = rc[ch];
			else if (above_s[Steps-1])
				pick[ch] = wc[ch];
			else
				pick[ch] = quo_s[Steps-1][ch];
		end
		out_res.visible = ~hide_s[Steps-1];
		out_res.red     = pick[0];
		out_res.green   = pick[1];
		out_res.blue    = pick[2];
		out_res.alpha   = pick[3];
	end

	assign out_valid = v_s[Steps-1];

endmodule
